@@ sv/mde_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular division package
// Shared widths, status codes, sequencer states and the structs that connect
// the sequencer with the top level and with the shift-subtract divider.
// ----------------------------------------------------------------------------
package mde_pkg;

  // Width of the modulus, the divisor and the quotient.
  localparam int unsigned ValueWidth = 16;
  // The dividend carries one extra sign bit.
  localparam int unsigned DivdWidth  = ValueWidth + 1;
  // Bezout coefficients stay within +/- modulus; two spare bits cover that.
  localparam int unsigned CoefWidth  = ValueWidth + 2;
  // Double width word for products and long divisions.
  localparam int unsigned ProdWidth  = 2 * ValueWidth;
  // Iteration counter of the divider, able to hold ProdWidth itself.
  localparam int unsigned CntWidth   = $clog2(ProdWidth + 1);

  localparam logic [ValueWidth-1:0] ModulusReset = ValueWidth'(2048);

  localparam logic StatusOk        = 1'b0;
  localparam logic StatusNoInverse = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EUC_CHK,
    S_EUC_DIV,
    S_EUC_MUL,
    S_EUC_UPD,
    S_INV,
    S_AMOD,
    S_PMUL,
    S_PMOD,
    S_PMOD_WAIT,
    S_DONE
  } seq_state_e;

  // Request to the divider. In short mode only the low ValueWidth bits of
  // the dividend take part and the unit runs ValueWidth steps.
  typedef struct packed {
    logic                  start;
    logic                  long_mode;
    logic [ProdWidth-1:0]  dividend;
    logic [ValueWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [ValueWidth-1:0] quotient;
    logic [ValueWidth-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic                        start;
    logic signed [DivdWidth-1:0] dividend;
    logic [ValueWidth-1:0]       divisor;
  } seq_req_t;

  typedef struct packed {
    logic                  idle;
    logic                  done;
    logic [ValueWidth-1:0] quotient;
    logic                  status;
  } seq_rsp_t;

endpackage

@@ sv/mde_intf.sv @@
// ----------------------------------------------------------------------------
// Modular division channels
// Valid/ready channels for the modulus write, the operands and the result.
// ----------------------------------------------------------------------------
interface mde_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mde_pkg::ValueWidth-1:0]      modulus;

  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

interface mde_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mde_pkg::DivdWidth-1:0] dividend;
  logic [mde_pkg::ValueWidth-1:0]      divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface

interface mde_out_if;
  logic                                valid;
  logic                                ready;
  logic [mde_pkg::ValueWidth-1:0]      quotient;
  logic                                status;

  modport source (output valid, quotient, status, input ready);
  modport sink   (input valid, quotient, status, output ready);
endinterface

@@ sv/mde_div.sv @@
// ----------------------------------------------------------------------------
// Shift-subtract divider
// Restoring division, one quotient bit per cycle, shared by all reductions.
// ----------------------------------------------------------------------------
module mde_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mde_pkg::div_req_t req_i,
  output mde_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic [mde_pkg::CntWidth-1:0]        cnt_q, cnt_d;
  logic [mde_pkg::ValueWidth-1:0]      rem_q;
  logic [mde_pkg::ProdWidth-1:0]       acc_q;
  logic [mde_pkg::ValueWidth-1:0]      dvs_q;
  logic [mde_pkg::ValueWidth:0]        shifted;
  logic [mde_pkg::ValueWidth+1:0]      diff;
  logic                                fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, acc_q[mde_pkg::ProdWidth-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[mde_pkg::ValueWidth+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.long_mode ? mde_pkg::CntWidth'(mde_pkg::ProdWidth)
                               : mde_pkg::CntWidth'(mde_pkg::ValueWidth);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      if (req_i.long_mode) begin
        acc_q <= req_i.dividend;
      end else begin
        acc_q <= {req_i.dividend[mde_pkg::ValueWidth-1:0], {mde_pkg::ValueWidth{1'b0}}};
      end
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= fits ? diff[mde_pkg::ValueWidth-1:0] : shifted[mde_pkg::ValueWidth-1:0];
      acc_q <= {acc_q[mde_pkg::ProdWidth-2:0], fits};
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = busy_q && (cnt_q == '0);
  assign rsp_o.quotient  = acc_q[mde_pkg::ValueWidth-1:0];
  assign rsp_o.remainder = rem_q;

  // A new division is only started once the previous one has finished.
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // The remainder handed out is always below the divisor.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> (rem_q < dvs_q))
    else $error("divider remainder not reduced");

  // Completion ends the run on the next cycle.
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done && !req_i.start |=> !busy_q)
    else $error("divider kept running after completion");

endmodule

@@ sv/mde_seq.sv @@
// ----------------------------------------------------------------------------
// Modular division sequencer
// Runs extended Euclid, the residue steps and the final product reduction
// on the shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
module mde_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mde_pkg::seq_req_t              req_i,
  input  logic [mde_pkg::ValueWidth-1:0] modulus_i,
  input  logic                           ack_i,
  input  mde_pkg::div_rsp_t              div_rsp_i,
  output mde_pkg::div_req_t              div_req_o,
  output mde_pkg::seq_rsp_t              rsp_o
);

  mde_pkg::seq_state_e state_q, state_d;

  logic [mde_pkg::ValueWidth-1:0]        r_prev_q, r_cur_q, q_q;
  logic signed [mde_pkg::CoefWidth-1:0]  s_prev_q, s_cur_q;
  logic signed [mde_pkg::DivdWidth-1:0]  a_q;
  logic [mde_pkg::ProdWidth-1:0]         prod_q;
  logic [mde_pkg::ValueWidth-1:0]        inv_q, ar_q, quo_q;
  logic                                  stat_q;

  logic [mde_pkg::ValueWidth-1:0]        mul_a, mul_b;
  logic [mde_pkg::ProdWidth-1:0]         mul_res;
  logic signed [mde_pkg::CoefWidth-1:0]  s_abs, prod_s, n_s, inv_sum;
  logic [mde_pkg::DivdWidth-1:0]         a_mag;
  logic [mde_pkg::ValueWidth-1:0]        ar_val;

  // Shared multiplier: quotient times |s| during Euclid, inverse times
  // residue of the dividend at the end.
  assign mul_res = mde_pkg::ProdWidth'(mul_a) * mde_pkg::ProdWidth'(mul_b);

  assign s_abs  = s_cur_q[mde_pkg::CoefWidth-1] ? -s_cur_q : s_cur_q;
  // |q * s| never exceeds twice the modulus, so the low bits are exact.
  assign prod_s = s_cur_q[mde_pkg::CoefWidth-1]
                ? -signed'(prod_q[mde_pkg::CoefWidth-1:0])
                : signed'(prod_q[mde_pkg::CoefWidth-1:0]);

  assign n_s = signed'({2'b00, modulus_i});
  always_comb begin
    if (s_prev_q < 0) begin
      inv_sum = s_prev_q + n_s;
    end else if (s_prev_q >= n_s) begin
      inv_sum = s_prev_q - n_s;
    end else begin
      inv_sum = s_prev_q;
    end
  end

  assign a_mag  = a_q[mde_pkg::ValueWidth] ? (~a_q + 1'b1) : a_q;
  assign ar_val = (a_q[mde_pkg::ValueWidth] && div_rsp_i.remainder != '0)
                ? modulus_i - div_rsp_i.remainder
                : div_rsp_i.remainder;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mde_pkg::S_IDLE: begin
        if (req_i.start) begin
          state_d = (modulus_i == '0) ? mde_pkg::S_DONE : mde_pkg::S_EUC_CHK;
        end
      end
      mde_pkg::S_EUC_CHK: begin
        if (r_cur_q != '0) begin
          state_d = mde_pkg::S_EUC_DIV;
        end else if (r_prev_q == mde_pkg::ValueWidth'(1)) begin
          state_d = mde_pkg::S_INV;
        end else begin
          state_d = mde_pkg::S_DONE;
        end
      end
      mde_pkg::S_EUC_DIV: begin
        if (div_rsp_i.done) begin
          state_d = mde_pkg::S_EUC_MUL;
        end
      end
      mde_pkg::S_EUC_MUL: state_d = mde_pkg::S_EUC_UPD;
      mde_pkg::S_EUC_UPD: state_d = mde_pkg::S_EUC_CHK;
      mde_pkg::S_INV:     state_d = mde_pkg::S_AMOD;
      mde_pkg::S_AMOD: begin
        if (div_rsp_i.done) begin
          state_d = mde_pkg::S_PMUL;
        end
      end
      mde_pkg::S_PMUL:    state_d = mde_pkg::S_PMOD;
      mde_pkg::S_PMOD:    state_d = mde_pkg::S_PMOD_WAIT;
      mde_pkg::S_PMOD_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = mde_pkg::S_DONE;
        end
      end
      mde_pkg::S_DONE: begin
        if (ack_i) begin
          state_d = mde_pkg::S_IDLE;
        end
      end
      default: state_d = mde_pkg::S_IDLE;
    endcase
  end

  // Outputs: divider requests and multiplier operands.
  always_comb begin
    div_req_o.start     = 1'b0;
    div_req_o.long_mode = 1'b1;
    div_req_o.dividend  = prod_q;
    div_req_o.divisor   = modulus_i;
    mul_a               = inv_q;
    mul_b               = ar_q;
    unique case (state_q)
      mde_pkg::S_EUC_CHK: begin
        div_req_o.start     = (r_cur_q != '0);
        div_req_o.long_mode = 1'b0;
        div_req_o.dividend  = mde_pkg::ProdWidth'(r_prev_q);
        div_req_o.divisor   = r_cur_q;
      end
      mde_pkg::S_EUC_MUL: begin
        mul_a = q_q;
        mul_b = s_abs[mde_pkg::ValueWidth-1:0];
      end
      mde_pkg::S_INV: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = mde_pkg::ProdWidth'(a_mag);
      end
      mde_pkg::S_PMOD: begin
        div_req_o.start = 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_o.idle     = (state_q == mde_pkg::S_IDLE);
  assign rsp_o.done     = (state_q == mde_pkg::S_DONE);
  assign rsp_o.quotient = quo_q;
  assign rsp_o.status   = stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mde_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mde_pkg::S_IDLE: begin
        if (req_i.start) begin
          r_prev_q <= req_i.divisor;
          r_cur_q  <= modulus_i;
          s_prev_q <= mde_pkg::CoefWidth'(1);
          s_cur_q  <= '0;
          a_q      <= req_i.dividend;
          quo_q    <= '0;
          stat_q   <= (modulus_i == '0) ? mde_pkg::StatusNoInverse : mde_pkg::StatusOk;
        end
      end
      mde_pkg::S_EUC_CHK: begin
        if (r_cur_q == '0 && r_prev_q != mde_pkg::ValueWidth'(1)) begin
          stat_q <= mde_pkg::StatusNoInverse;
        end
      end
      mde_pkg::S_EUC_DIV: begin
        if (div_rsp_i.done) begin
          q_q      <= div_rsp_i.quotient;
          r_prev_q <= r_cur_q;
          r_cur_q  <= div_rsp_i.remainder;
        end
      end
      mde_pkg::S_EUC_MUL: prod_q <= mul_res;
      mde_pkg::S_EUC_UPD: begin
        s_prev_q <= s_cur_q;
        s_cur_q  <= s_prev_q - prod_s;
      end
      mde_pkg::S_INV: inv_q <= inv_sum[mde_pkg::ValueWidth-1:0];
      mde_pkg::S_AMOD: begin
        if (div_rsp_i.done) begin
          ar_q <= ar_val;
        end
      end
      mde_pkg::S_PMUL: prod_q <= mul_res;
      mde_pkg::S_PMOD_WAIT: begin
        if (div_rsp_i.done) begin
          quo_q  <= div_rsp_i.remainder;
          stat_q <= mde_pkg::StatusOk;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/modular_division_ext_euclid.sv @@
// ----------------------------------------------------------------------------
// Modular division by extended Euclid
// Returns dividend * divisor^-1 mod N, or status no-inverse when
// gcd(divisor, N) is not 1; N comes from the modulus register.
//
// An item runs k Euclid quotient steps, k being 1 to about 24 for 16-bit
// values, and when an inverse exists then the inverse, residue and product
// steps. A missing inverse is reported once the Euclid steps end, and a zero
// modulus goes straight to the result without any Euclid step.
// The bit-serial divider produces one quotient bit per cycle.
// One item is in flight at a time; the next input beat is taken once the
// result has moved to the output register.
// Reset clears the control state and loads the modulus register with 2048.
// ----------------------------------------------------------------------------
module modular_division_ext_euclid (
  input  logic        clk_i,
  input  logic        rst_ni,
  mde_cfg_if.sink     cfg_if,
  mde_in_if.sink      in_if,
  mde_out_if.source   out_if
);

  // Modulus register; writes are accepted every cycle. The user writes it only
  // while the block is idle, so the sequencer sees a stable value (unchecked).
  logic [mde_pkg::ValueWidth-1:0] modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mde_pkg::ModulusReset;
    end else if (cfg_if.valid && cfg_if.ready) begin
      modulus_q <= cfg_if.modulus;
    end
  end

  assign cfg_if.ready = 1'b1;

  // Sequencer and the shared divider it drives.
  mde_pkg::seq_req_t seq_req;
  mde_pkg::seq_rsp_t seq_rsp;
  mde_pkg::div_req_t div_req;
  mde_pkg::div_rsp_t div_rsp;
  logic              seq_ack;

  // The operands are taken only while the sequencer sits idle.
  assign in_if.ready      = seq_rsp.idle;
  assign seq_req.start    = in_if.valid && in_if.ready;
  assign seq_req.dividend = in_if.dividend;
  assign seq_req.divisor  = in_if.divisor;

  mde_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (seq_req),
    .modulus_i (modulus_q),
    .ack_i     (seq_ack),
    .div_rsp_i (div_rsp),
    .div_req_o (div_req),
    .rsp_o     (seq_rsp)
  );

  mde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register. A finished result moves here whenever the register
  // is empty or its current beat is being taken, which frees the
  // sequencer for the next item while the result waits downstream.
  logic                           out_valid_q, out_valid_d;
  logic [mde_pkg::ValueWidth-1:0] out_quotient_q;
  logic                           out_status_q;

  assign seq_ack = !out_valid_q || out_if.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_rsp.done && seq_ack) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_rsp.done && seq_ack) begin
      out_quotient_q <= seq_rsp.quotient;
      out_status_q   <= seq_rsp.status;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.quotient = out_quotient_q;
  assign out_if.status   = out_status_q;

  // An accepted beat always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !seq_rsp.idle)
    else $error("input beat accepted but sequencer stayed idle");

  // A no-inverse result carries a zero quotient.
  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == mde_pkg::StatusNoInverse |-> out_quotient_q == '0)
    else $error("no-inverse result with nonzero quotient");

  // A good result is a proper residue of the modulus.
  a_ok_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == mde_pkg::StatusOk |-> out_quotient_q < modulus_q)
    else $error("quotient not reduced below the modulus");

endmodule

@@ tb/modular_division_ext_euclid_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular division testbench
// Sends signed dividends and unsigned divisors through the operand channel
// under a series of modulus settings. Each result beat is checked against a
// table entry or the bench's own extended Euclid model. Both channels idle
// at random, and once the result side holds off to back up the operand side.
// ----------------------------------------------------------------------------
module modular_division_ext_euclid_tb;
  import mde_pkg::*;

  // Clock period is 4 ns. The run is cut off after this many cycles.
  localparam int CycleLimit   = 4_000_000;
  // This many quiet cycles at the end will expose any stray result beat.
  localparam int TailCycles   = 600;
  // These cycles sit between the last result and a modulus write.
  localparam int SettleCycles = 8;
  localparam int RandomPhases = 10;
  localparam int PhaseItems   = 113;
  // The result side holds off once, at this result count, for this long.
  // That point falls inside the first random phase, while the sender is
  // still offering operands.
  localparam int PressureAt   = 64;
  localparam int PressureHold = 2000;

  typedef enum logic [1:0] {
    ROW_SET_MODULUS,
    ROW_PREDICTED,
    ROW_KNOWN
  } row_kind_e;

  // A set row carries the new modulus in the divisor column.
  typedef struct packed {
    row_kind_e kind;
    int        dividend;
    int        divisor;
    int        quotient;
    logic      status;
  } stim_row_t;

  typedef struct packed {
    logic [ValueWidth-1:0] quotient;
    logic                  status;
  } quot_rsp_t;

  localparam int DirectedCount = 27;

  // Directed rows. A known row gives its expected result in the table.
  // A predicted row is checked against the Euclid model below.
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    // These rows run with the modulus at its reset value of 2048.
    '{ROW_KNOWN,          1,     1,    1, StatusOk},
    '{ROW_KNOWN,          0,     0,    0, StatusNoInverse},
    '{ROW_KNOWN,          5,     2,    0, StatusNoInverse},
    '{ROW_KNOWN,         -1,     1, 2047, StatusOk},
    '{ROW_KNOWN,     -65536,     1,    0, StatusOk},
    '{ROW_KNOWN,      65535,     1, 2047, StatusOk},
    '{ROW_KNOWN,          3,     3,    1, StatusOk},
    '{ROW_KNOWN,        100,  2049,  100, StatusOk},
    '{ROW_PREDICTED,      7, 65535,    0, StatusOk},
    '{ROW_PREDICTED, -12345, 43691,    0, StatusOk},
    // Modulus 2 leaves only residues 0 and 1.
    '{ROW_SET_MODULUS,    0,     2,    0, StatusOk},
    '{ROW_KNOWN,          1,     1,    1, StatusOk},
    '{ROW_KNOWN,         -1,     1,    1, StatusOk},
    '{ROW_KNOWN,          5,     0,    0, StatusNoInverse},
    '{ROW_KNOWN,     -65536, 65535,    0, StatusOk},
    '{ROW_KNOWN,      65535, 65535,    1, StatusOk},
    // With the largest modulus, the divisor can equal the modulus itself.
    '{ROW_SET_MODULUS,    0, 65535,    0, StatusOk},
    '{ROW_KNOWN,      65535,     1,    0, StatusOk},
    '{ROW_KNOWN,     -65536,     1, 65534, StatusOk},
    '{ROW_KNOWN,          1, 65535,    0, StatusNoInverse},
    '{ROW_KNOWN,          1,     3,    0, StatusNoInverse},
    '{ROW_PREDICTED,     -1, 65534,    0, StatusOk},
    '{ROW_PREDICTED,  12345, 65534,    0, StatusOk},
    // Consecutive Fibonacci numbers 46368 and 28657 force the longest Euclid chain.
    '{ROW_SET_MODULUS,    0, 46368,    0, StatusOk},
    '{ROW_PREDICTED, -65536, 28657,    0, StatusOk},
    '{ROW_PREDICTED,  65535, 17711,    0, StatusOk},
    '{ROW_KNOWN,          1,     0,    0, StatusNoInverse}
  };

  logic clk;
  logic rst_n;

  mde_cfg_if cfg_ch ();
  mde_in_if  in_ch ();
  mde_out_if out_ch ();

  modular_division_ext_euclid dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_if (cfg_ch),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // The queue holds the expected results, oldest first. Operand beats
  // append to it and result beats remove from it.
  quot_rsp_t             expected_quotients [$];
  logic [ValueWidth-1:0] modulus_shadow;
  int                    fail_count      = 0;
  int                    cycle_count     = 0;
  int                    operand_beats   = 0;
  int                    results_seen    = 0;
  int                    no_inverse_seen = 0;
  int                    settings_written = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // This is the expected result for one operand pair under modulus n. The
  // extended Euclid loop on (divisor, n) gives the gcd in rem_a and the
  // Bezout coefficient of the divisor in coef_a. A gcd other than one means
  // no inverse exists. A 64-bit signed value holds every coefficient and
  // every product, so the arithmetic is exact.
  function automatic quot_rsp_t divide_mod(input logic signed [DivdWidth-1:0] num,
                                           input logic [ValueWidth-1:0] den,
                                           input logic [ValueWidth-1:0] n);
    longint    m;
    longint    rem_a;
    longint    rem_b;
    longint    coef_a;
    longint    coef_b;
    longint    q;
    longint    t;
    longint    inv;
    longint    num_res;
    quot_rsp_t res;
    res.quotient = '0;
    res.status   = StatusNoInverse;
    m = longint'(n);
    if (m == 0) return res;
    rem_a  = longint'(den);
    rem_b  = m;
    coef_a = 1;
    coef_b = 0;
    while (rem_b != 0) begin
      q      = rem_a / rem_b;
      t      = rem_a - q * rem_b;
      rem_a  = rem_b;
      rem_b  = t;
      t      = coef_a - q * coef_b;
      coef_a = coef_b;
      coef_b = t;
    end
    if (rem_a != 1) return res;
    // The % operator truncates toward zero, so a negative result is moved
    // up into 0..m-1.
    inv = coef_a % m;
    if (inv < 0) inv += m;
    num_res = longint'(num) % m;
    if (num_res < 0) num_res += m;
    res.quotient = ValueWidth'((inv * num_res) % m);
    res.status   = StatusOk;
    return res;
  endfunction

  // This task offers one operand beat and holds it until the block takes it.
  // The expected result is queued at the edge where the beat is accepted.
  // Valid stays high after acceptance. The caller either offers the next
  // beat at once or lowers valid for a gap.
  task automatic offer_operands(input logic signed [DivdWidth-1:0] num,
                                input logic [ValueWidth-1:0] den,
                                input logic known,
                                input quot_rsp_t typed);
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= num;
    in_ch.divisor  <= den;
    do @(posedge clk); while (!in_ch.ready);
    expected_quotients.push_back(known ? typed : divide_mod(num, den, modulus_shadow));
    operand_beats++;
  endtask

  // Without idling there is no gap; otherwise most gaps are short and a few long.
  task automatic pause_sender(input bit idles);
    int gap;
    gap = 0;
    if (idles) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // This task lowers valid and waits until every result has come back, so
  // the block is idle and the modulus may change.
  task automatic wait_until_drained;
    in_ch.valid <= 1'b0;
    while (expected_quotients.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [ValueWidth-1:0] value);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid   <= 1'b0;
    modulus_shadow = value;
    settings_written++;
  endtask

  // This process checks each result beat against the oldest expectation.
  initial begin : result_sink
    int        stall_left;
    bit        stalls;
    bit        pressure_done;
    quot_rsp_t want;
    stall_left    = 0;
    stalls        = 1'b1;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.status == StatusNoInverse) no_inverse_seen++;
        if (expected_quotients.size() == 0) begin
          $error("result beat with nothing outstanding: quotient %0d status %0d",
                 out_ch.quotient, out_ch.status);
          fail_count++;
        end else begin
          want = expected_quotients.pop_front();
          if (out_ch.quotient !== want.quotient) begin
            $error("quotient mismatch: expected %0d, actual %0d",
                   want.quotient, out_ch.quotient);
            fail_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_ch.status);
            fail_count++;
          end
        end
        // Stalling turns on and off in stretches, so some stretches run
        // with ready held high.
        if (results_seen % 50 == 0) stalls = ($urandom_range(0, 3) != 0);
        if (!pressure_done && results_seen == PressureAt) begin
          stall_left    = PressureHold;
          pressure_done = 1'b1;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (stalls && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4);
        end
      end
    end
  end

  // This process drives reset, the directed table, the random phases and
  // the end of the run.
  initial begin : stimulus
    stim_row_t                   row;
    quot_rsp_t                   typed;
    logic signed [DivdWidth-1:0] num;
    logic [ValueWidth-1:0]       den;
    logic [ValueWidth-1:0]       new_mod;
    bit                          sender_idles;
    rst_n          <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.modulus <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.dividend <= '0;
    in_ch.divisor  <= '0;
    modulus_shadow = ModulusReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part starts before any write, so the first rows check
    // the modulus that reset leaves in the register.
    for (int i = 0; i < DirectedCount; i++) begin
      row = DirectedRows[i];
      if (row.kind == ROW_SET_MODULUS) begin
        wait_until_drained();
        write_modulus(row.divisor[ValueWidth-1:0]);
      end else begin
        typed.quotient = row.quotient[ValueWidth-1:0];
        typed.status   = row.status;
        offer_operands(row.dividend[DivdWidth-1:0], row.divisor[ValueWidth-1:0],
                       row.kind == ROW_KNOWN, typed);
        pause_sender(1'b1);
      end
    end

    // Each random phase sets its own modulus. Odd and prime moduli send most
    // divisors down the full Euclid, inverse and product path. Even moduli
    // mix in many divisors that have no inverse.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       new_mod = 16'd65521;
        1:       new_mod = 16'd2;
        2:       new_mod = 16'd65535;
        3:       new_mod = 16'd3;
        4:       new_mod = ValueWidth'($urandom_range(2, 255));
        6:       new_mod = ModulusReset;
        7:       new_mod = ValueWidth'($urandom_range(32768, 65535));
        8:       new_mod = 16'd46368;
        default: new_mod = ValueWidth'($urandom_range(2, 65535));
      endcase
      wait_until_drained();
      write_modulus(new_mod);
      sender_idles = (phase % 4 != 1);
      for (int k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 9))
          0:       num = {1'b1, {ValueWidth{1'b0}}};
          1:       num = {1'b0, {ValueWidth{1'b1}}};
          2:       num = DivdWidth'($urandom_range(0, 15)) - DivdWidth'(8);
          default: num = DivdWidth'($urandom);
        endcase
        case ($urandom_range(0, 11))
          0:       den = '0;
          1:       den = ValueWidth'($urandom_range(1, 15));
          2:       den = modulus_shadow - 1'b1;
          3:       den = modulus_shadow + ValueWidth'($urandom_range(0, 3));
          4:       den = ValueWidth'($urandom) | 16'h0001;
          5:       den = ValueWidth'($urandom_range(1, 65535)) % modulus_shadow;
          default: den = ValueWidth'($urandom);
        endcase
        offer_operands(num, den, 1'b0, '0);
        pause_sender(sender_idles);
      end
    end

    // After the last operand, wait out every result and then a quiet
    // stretch long enough for a stray beat to show up.
    wait_until_drained();
    repeat (TailCycles) @(posedge clk);
    $display("Run covered %0d operand beats under %0d modulus writes.",
             operand_beats, settings_written);
    $display("%0d results came back, %0d of them reporting no inverse.",
             results_seen, no_inverse_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mde_pkg.sv
sv/mde_intf.sv
sv/mde_div.sv
sv/mde_seq.sv
sv/modular_division_ext_euclid.sv
tb/modular_division_ext_euclid_tb.sv
